>>> rtl/seir_pkg.sv
`default_nettype none

package seir_pkg;

    // default sizes of the counts
    localparam int COUNT_BITS_DEF = 48;
    localparam int FRAC_BITS_DEF  = 16;

    // register field widths
    localparam int RATE_W    = 17;
    localparam int CONTACT_W = 8;
    localparam int POP_W     = 32;
    localparam int KMUL_W    = RATE_W + CONTACT_W;
    localparam int ACTION_W  = 3;
    localparam int CFG_IDX_W = 3;

    // item actions
    localparam logic [ACTION_W-1:0] ACT_STEP      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_ALL  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_EIR  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_LOAD_IR   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_LOAD_I    = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_R2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POP   = 3'd6;

    // term indexes of a step
    localparam logic [1:0] TERM_INF1 = 2'd0;
    localparam logic [1:0] TERM_INF2 = 2'd1;
    localparam logic [1:0] TERM_AE   = 2'd2;
    localparam logic [1:0] TERM_GI   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL1,
        ST_DIV,
        ST_MUL2,
        ST_COMBINE,
        ST_DERIVE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/seir_epidemic_step_top.sv
`default_nettype none

// Discrete-time SEIR epidemic stepper on signed fixed-point counts. A step
// item (action 0) computes four terms. Each of the two infection terms runs
// three stages: a bit-serial shift-add multiply of the counts, a restoring
// divide by the population and a bit-serial multiply by the contact rate
// times beta. The two rate terms run only the last multiply. Each of the
// four terms also has a setup state and a store step. The combine state
// applies the saturating updates, the done state loads the output register
// once the output is free, and the block then returns to idle. Load items
// go straight to the done state, or through the derive state when S is
// derived from the population. One item is in work at a time; a finished
// result sits in the output register while the next item is taken.
// Configuration writes are always ready.
module seir_epidemic_step_top
#(
    parameter int COUNT_BITS = seir_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = seir_pkg::FRAC_BITS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [seir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [seir_pkg::POP_W-1:0]         cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [seir_pkg::ACTION_W-1:0]      action,
    input  wire logic signed [COUNT_BITS-1:0]       s_value,
    input  wire logic signed [COUNT_BITS-1:0]       e_value,
    input  wire logic signed [COUNT_BITS-1:0]       i_value,
    input  wire logic signed [COUNT_BITS-1:0]       r_value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [COUNT_BITS-1:0]            susceptible,
    output logic signed [COUNT_BITS-1:0]            exposed,
    output logic signed [COUNT_BITS-1:0]            infectious,
    output logic signed [COUNT_BITS-1:0]            recovered
);
    import seir_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam int PW = 2 * COUNT_BITS;
    localparam int AW = PW + KMUL_W;
    localparam int CW = $clog2(PW + 1);
    localparam logic [CB-1:0] CNT_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] CNT_MIN = {1'b1, {(CB-1){1'b0}}};

    // saturating add or subtract on counts
    function automatic logic [CB-1:0] sat_op(input logic [CB-1:0] a,
                                             input logic [CB-1:0] b,
                                             input logic sub);
        logic [CB-1:0] bb;
        logic [CB:0]   sum;
        bb  = sub ? ~b : b;
        sum = {a[CB-1], a} + {bb[CB-1], bb} + {{CB{1'b0}}, sub};
        if (sum[CB] != sum[CB-1])
            return sum[CB] ? CNT_MIN : CNT_MAX;
        return sum[CB-1:0];
    endfunction

    function automatic logic [CB-1:0] mag(input logic [CB-1:0] x);
        return x[CB-1] ? (~x + {{(CB-1){1'b0}}, 1'b1}) : x;
    endfunction

    // configuration registers
    logic [RATE_W-1:0]    alpha_reg, beta1_reg, gamma_reg, beta2_reg;
    logic [CONTACT_W-1:0] r1_reg, r2_reg;
    logic [POP_W-1:0]     pop_reg;

    // state and datapath
    state_t         state_reg, state_next;
    logic [CB-1:0]  s_reg, e_reg, i_reg, r_reg;
    logic [CB-1:0]  t_reg [4];
    logic [1:0]     term_reg;
    logic [1:0]     sub_reg;
    logic           neg_reg;
    logic [CW-1:0]  cnt_reg;
    logic [AW-1:0]  acc_reg;
    logic [PW-1:0]  mcand_reg;
    logic [CB-1:0]  mplier_reg;
    logic [KMUL_W-1:0] kmul_reg;
    logic [POP_W-1:0]  rem_reg;
    logic           out_valid_reg;
    logic [CB-1:0]  out_s_reg, out_e_reg, out_i_reg, out_r_reg;

    logic           in_xfer;
    logic           out_load;
    logic [POP_W-1:0] divisor;
    logic [POP_W:0] rem_shift;
    logic           q_bit;
    logic [AW-1:0]  add_term;
    logic [AW-1:0]  shifted;
    logic [CB-1:0]  cap;
    logic [CB-1:0]  term_mag;
    logic [CB-1:0]  term_val;
    logic [CB+POP_W-1:0] n_scaled;
    logic [CB-1:0]  n_sat;
    logic [KMUL_W-1:0] k1, k2;

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign susceptible = out_s_reg;
    assign exposed     = out_e_reg;
    assign infectious  = out_i_reg;
    assign recovered   = out_r_reg;

    // handshake controls
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        in_xfer  = in_valid && !in_stall;
        out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    end

    // arithmetic helpers
    always_comb
    begin
        divisor   = (pop_reg == '0) ? {{(POP_W-1){1'b0}}, 1'b1} : pop_reg;
        rem_shift = {rem_reg, acc_reg[PW-1]};
        q_bit     = rem_shift >= {1'b0, divisor};
        add_term  = mplier_reg[CB-1] ? AW'(mcand_reg) : '0;
        k1        = KMUL_W'(r1_reg) * KMUL_W'(beta1_reg);
        k2        = KMUL_W'(r2_reg) * KMUL_W'(beta2_reg);
        shifted   = (term_reg == TERM_INF1 || term_reg == TERM_INF2)
                    ? (acc_reg >> (2 * FRAC_BITS)) : (acc_reg >> FRAC_BITS);
        cap       = neg_reg ? CNT_MIN : CNT_MAX;
        term_mag  = ((|shifted[AW-1:CB]) || (shifted[CB-1:0] > cap))
                    ? cap : shifted[CB-1:0];
        term_val  = neg_reg ? (~term_mag + {{(CB-1){1'b0}}, 1'b1}) : term_mag;
        n_scaled  = (CB+POP_W)'(pop_reg) << FRAC_BITS;
        n_sat     = (n_scaled > (CB+POP_W)'(CNT_MAX)) ? CNT_MAX : n_scaled[CB-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (action)
                        ACT_STEP:                  state_next = ST_SETUP;
                        ACT_LOAD_EIR, ACT_LOAD_IR: state_next = ST_DERIVE;
                        default:                   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SETUP:
                state_next = (term_reg == TERM_INF1 || term_reg == TERM_INF2)
                             ? ST_MUL1 : ST_MUL2;
            ST_MUL1:
                if (cnt_reg == CW'(1)) state_next = ST_DIV;
            ST_DIV:
                if (cnt_reg == CW'(1)) state_next = ST_MUL2;
            ST_MUL2:
                if (cnt_reg == '0)
                    state_next = (term_reg == TERM_GI) ? ST_COMBINE : ST_SETUP;
            ST_COMBINE:
                if (sub_reg == 2'd2) state_next = ST_DONE;
            ST_DERIVE:
                if (sub_reg == 2'd3) state_next = ST_DONE;
            ST_DONE:
                if (out_load) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            alpha_reg     <= '0;
            beta1_reg     <= '0;
            gamma_reg     <= '0;
            beta2_reg     <= '0;
            r1_reg        <= '0;
            r2_reg        <= '0;
            pop_reg       <= {{(POP_W-1){1'b0}}, 1'b1};
            s_reg         <= '0;
            e_reg         <= '0;
            i_reg         <= '0;
            r_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ALPHA: alpha_reg <= cfg_data[RATE_W-1:0];
                    REG_BETA1: beta1_reg <= cfg_data[RATE_W-1:0];
                    REG_GAMMA: gamma_reg <= cfg_data[RATE_W-1:0];
                    REG_BETA2: beta2_reg <= cfg_data[RATE_W-1:0];
                    REG_R1:    r1_reg    <= cfg_data[CONTACT_W-1:0];
                    REG_R2:    r2_reg    <= cfg_data[CONTACT_W-1:0];
                    REG_POP:   pop_reg   <= cfg_data;
                    default: ;
                endcase
            end

            // count updates
            if (in_xfer)
            begin
                case (action)
                    ACT_LOAD_ALL:
                    begin
                        s_reg <= s_value;
                        e_reg <= e_value;
                        i_reg <= i_value;
                        r_reg <= r_value;
                    end
                    ACT_LOAD_EIR:
                    begin
                        e_reg <= e_value;
                        i_reg <= i_value;
                        r_reg <= r_value;
                    end
                    ACT_LOAD_IR:
                    begin
                        i_reg <= i_value;
                        r_reg <= r_value;
                    end
                    ACT_LOAD_I:
                        i_reg <= i_value;
                    default: ;
                endcase
            end
            else if (state_reg == ST_COMBINE)
            begin
                case (sub_reg)
                    2'd0:
                    begin
                        s_reg <= sat_op(s_reg, t_reg[TERM_INF1], 1'b1);
                        e_reg <= sat_op(e_reg, t_reg[TERM_INF1], 1'b0);
                        i_reg <= sat_op(i_reg, t_reg[TERM_AE], 1'b0);
                        r_reg <= sat_op(r_reg, t_reg[TERM_GI], 1'b0);
                    end
                    2'd1:
                    begin
                        s_reg <= sat_op(s_reg, t_reg[TERM_INF2], 1'b1);
                        e_reg <= sat_op(e_reg, t_reg[TERM_AE], 1'b1);
                        i_reg <= sat_op(i_reg, t_reg[TERM_GI], 1'b1);
                    end
                    default:
                        e_reg <= sat_op(e_reg, t_reg[TERM_INF2], 1'b0);
                endcase
            end
            else if (state_reg == ST_DERIVE)
            begin
                case (sub_reg)
                    2'd0:    s_reg <= n_sat;
                    2'd1:    s_reg <= sat_op(s_reg, i_reg, 1'b1);
                    2'd2:    s_reg <= sat_op(s_reg, e_reg, 1'b1);
                    default: s_reg <= sat_op(s_reg, r_reg, 1'b1);
                endcase
            end
        end
    end

    // serial datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                term_reg <= TERM_INF1;
                sub_reg  <= '0;
            end
            ST_SETUP:
            begin
                acc_reg <= '0;
                case (term_reg)
                    TERM_INF1:
                    begin
                        mcand_reg  <= PW'(mag(i_reg));
                        mplier_reg <= mag(s_reg);
                        neg_reg    <= i_reg[CB-1] ^ s_reg[CB-1];
                        kmul_reg   <= k1;
                        cnt_reg    <= CW'(CB);
                    end
                    TERM_INF2:
                    begin
                        mcand_reg  <= PW'(mag(e_reg));
                        mplier_reg <= mag(s_reg);
                        neg_reg    <= e_reg[CB-1] ^ s_reg[CB-1];
                        kmul_reg   <= k2;
                        cnt_reg    <= CW'(CB);
                    end
                    TERM_AE:
                    begin
                        mcand_reg  <= PW'(mag(e_reg));
                        mplier_reg <= {KMUL_W'(alpha_reg), {(CB-KMUL_W){1'b0}}};
                        neg_reg    <= e_reg[CB-1];
                        cnt_reg    <= CW'(KMUL_W);
                    end
                    default:
                    begin
                        mcand_reg  <= PW'(mag(i_reg));
                        mplier_reg <= {KMUL_W'(gamma_reg), {(CB-KMUL_W){1'b0}}};
                        neg_reg    <= i_reg[CB-1];
                        cnt_reg    <= CW'(KMUL_W);
                    end
                endcase
            end
            ST_MUL1:
            begin
                acc_reg    <= (acc_reg << 1) + add_term;
                mplier_reg <= mplier_reg << 1;
                if (cnt_reg == CW'(1))
                begin
                    cnt_reg <= CW'(PW);
                    rem_reg <= '0;
                end
                else
                    cnt_reg <= cnt_reg - CW'(1);
            end
            ST_DIV:
            begin
                if (cnt_reg == CW'(1))
                begin
                    // quotient becomes the multiplicand of the rate multiply
                    mcand_reg  <= {acc_reg[PW-2:0], q_bit};
                    acc_reg    <= '0;
                    mplier_reg <= {kmul_reg, {(CB-KMUL_W){1'b0}}};
                    cnt_reg    <= CW'(KMUL_W);
                end
                else
                begin
                    rem_reg <= q_bit ? POP_W'(rem_shift - {1'b0, divisor})
                                     : rem_shift[POP_W-1:0];
                    acc_reg[PW-1:0] <= {acc_reg[PW-2:0], q_bit};
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
            ST_MUL2:
            begin
                if (cnt_reg == '0)
                begin
                    t_reg[term_reg] <= term_val;
                    term_reg        <= term_reg + 2'd1;
                end
                else
                begin
                    acc_reg    <= (acc_reg << 1) + add_term;
                    mplier_reg <= mplier_reg << 1;
                    cnt_reg    <= cnt_reg - CW'(1);
                end
            end
            ST_COMBINE, ST_DERIVE:
                sub_reg <= sub_reg + 2'd1;
            default: ;
        endcase

        // output register
        if (out_load)
        begin
            out_s_reg <= s_reg;
            out_e_reg <= e_reg;
            out_i_reg <= i_reg;
            out_r_reg <= r_reg;
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import seir_pkg::*;

    localparam int CW = 48;
    localparam int FB = 16;
    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam longint CYCLE_LIMIT = 64'd4000000;

    typedef struct packed {
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] e;
        logic signed [CW-1:0] i;
        logic signed [CW-1:0] r;
    } counts_t;

    // epidemic predictor and store of expected counts
    class seir_scoreboard;
        logic [16:0] alpha, beta1, gamma, beta2;
        logic [7:0]  r1, r2;
        logic [31:0] pop;
        longint cs, ce, ci, cr;
        counts_t pending[$];
        int errors;

        function new();
            alpha = 0; beta1 = 0; gamma = 0; beta2 = 0;
            r1 = 0; r2 = 0; pop = 1;
            cs = 0; ce = 0; ci = 0; cr = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                REG_ALPHA: alpha = d[16:0];
                REG_BETA1: beta1 = d[16:0];
                REG_GAMMA: gamma = d[16:0];
                REG_BETA2: beta2 = d[16:0];
                REG_R1:    r1 = d[7:0];
                REG_R2:    r2 = d[7:0];
                REG_POP:   pop = d;
                default: ;
            endcase
        endfunction

        function longint sadd(longint a, longint b);
            longint t;
            t = a + b;
            if (t > CMAX) return CMAX;
            if (t < CMIN) return CMIN;
            return t;
        endfunction

        function longint ssub(longint a, longint b);
            longint t;
            t = a - b;
            if (t > CMAX) return CMAX;
            if (t < CMIN) return CMIN;
            return t;
        endfunction

        // sign * trunc(trunc(a*b/div)*k / 2^shift), saturated
        function longint term(longint x, longint y, logic neg, logic [31:0] dv,
                              logic [31:0] k, int shift);
            logic [191:0] p;
            logic [191:0] cap;
            p = 192'(x) * 192'(y);
            p = p / 192'((dv == 0) ? 32'd1 : dv);
            p = (p * 192'(k)) >> shift;
            cap = neg ? 192'(CMAX) + 1 : 192'(CMAX);
            if (p > cap) p = cap;
            return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
        endfunction

        function longint mag(longint x);
            return x < 0 ? -x : x;
        endfunction

        function longint derive_s();
            longint v;
            logic [63:0] n;
            n = 64'(pop) << FB;
            v = (n > 64'(CMAX)) ? CMAX : longint'(n);
            v = ssub(v, ci);
            v = ssub(v, ce);
            return ssub(v, cr);
        endfunction

        // note an accepted input transfer
        function void note_input(logic [2:0] act, longint sv, longint ev,
                                 longint iv, longint rv);
            longint inf1, inf2, ae, gi, s, e, i, r;
            counts_t c;
            case (act)
                ACT_STEP:
                begin
                    s = cs; e = ce; i = ci; r = cr;
                    inf1 = term(mag(i), mag(s), (i < 0) != (s < 0), pop,
                                32'(r1) * 32'(beta1), 2 * FB);
                    inf2 = term(mag(e), mag(s), (e < 0) != (s < 0), pop,
                                32'(r2) * 32'(beta2), 2 * FB);
                    ae = term(mag(e), 1, e < 0, 1, 32'(alpha), FB);
                    gi = term(mag(i), 1, i < 0, 1, 32'(gamma), FB);
                    cs = ssub(ssub(s, inf1), inf2);
                    ce = sadd(ssub(sadd(e, inf1), ae), inf2);
                    ci = ssub(sadd(i, ae), gi);
                    cr = sadd(r, gi);
                end
                ACT_LOAD_ALL:
                begin
                    cs = sv; ce = ev; ci = iv; cr = rv;
                end
                ACT_LOAD_EIR:
                begin
                    ce = ev; ci = iv; cr = rv; cs = derive_s();
                end
                ACT_LOAD_IR:
                begin
                    ci = iv; cr = rv; cs = derive_s();
                end
                ACT_LOAD_I: ci = iv;
                default: ;
            endcase
            c.s = cs[CW-1:0]; c.e = ce[CW-1:0]; c.i = ci[CW-1:0]; c.r = cr[CW-1:0];
            pending.push_back(c);
        endfunction

        // check a result transfer against the oldest expectation
        function void check_result(counts_t got);
            counts_t x;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (got.s !== x.s)
            begin
                $error("susceptible: expected %0d actual %0d", x.s, got.s); errors++;
            end
            if (got.e !== x.e)
            begin
                $error("exposed: expected %0d actual %0d", x.e, got.e); errors++;
            end
            if (got.i !== x.i)
            begin
                $error("infectious: expected %0d actual %0d", x.i, got.i); errors++;
            end
            if (got.r !== x.r)
            begin
                $error("recovered: expected %0d actual %0d", x.r, got.r); errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [POP_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ACTION_W-1:0] action = '0;
    logic signed [CW-1:0] s_value = '0, e_value = '0, i_value = '0, r_value = '0;
    logic out_valid;
    logic out_stall;
    logic signed [CW-1:0] susceptible, exposed, infectious, recovered;

    seir_scoreboard sb;
    longint cycles = 0;
    bit out_gaps = 1'b1;
    int out_wait = 0;

    seir_epidemic_step_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .s_value(s_value), .e_value(e_value),
        .i_value(i_value), .r_value(r_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .susceptible(susceptible), .exposed(exposed),
        .infectious(infectious), .recovered(recovered)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("seir_epidemic_step_top regression: fail");
            $finish;
        end
    end

    // result side: stall for a random wait after each accepted result when gaps are on
    assign out_stall = (out_wait != 0);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_result({susceptible, exposed, infectious, recovered});
                out_wait <= out_gaps ? int'($urandom_range(0, 16)) : 0;
            end
            else if (out_valid && out_wait != 0)
                out_wait <= out_wait - 1;
        end
    end

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send(logic [2:0] act, longint sv, longint ev, longint iv, longint rv,
                        bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 16) : 0;
        repeat (w) @(posedge clk);
        in_valid <= 1'b1;
        action <= act;
        s_value <= sv[CW-1:0]; e_value <= ev[CW-1:0];
        i_value <= iv[CW-1:0]; r_value <= rv[CW-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(act, sv, ev, iv, rv);
        in_valid <= 1'b0;
        // the block is busy right after a transfer
        @(posedge clk);
    endtask

    function automatic longint rnd_count(int mode);
        longint v;
        v = {$urandom, $urandom};
        case (mode)
            0: return longint'($urandom_range(0, 200000)) <<< FB;
            1: return (v <<< 16) >>> 16;
            default: return $urandom_range(0, 1) ? CMAX : CMIN;
        endcase
    endfunction

    task automatic set_rates(bit extreme);
        write_cfg(REG_ALPHA, extreme ? 32'd65536 : $urandom_range(0, 20000));
        write_cfg(REG_BETA1, extreme ? 32'h1FFFF : $urandom_range(0, 30000));
        write_cfg(REG_GAMMA, extreme ? 32'd131071 : $urandom_range(0, 20000));
        write_cfg(REG_BETA2, extreme ? 32'd65536 : $urandom_range(0, 65536));
        write_cfg(REG_R1, extreme ? 32'd255 : $urandom_range(0, 20));
        write_cfg(REG_R2, extreme ? 32'd255 : $urandom_range(0, 255));
        write_cfg(REG_POP, extreme ? 32'hFFFFFFFF : $urandom_range(1, 1000000));
    endtask

    initial
    begin
        int k, n, sel;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, extremes and special cases
        send(ACT_STEP, 0, 0, 0, 0, 0);
        drain();
        set_rates(1'b1);
        send(ACT_LOAD_ALL, CMAX, CMAX, CMAX, CMAX, 0);
        send(ACT_STEP, 0, 0, 0, 0, 0);
        send(ACT_LOAD_ALL, CMIN, CMIN, CMIN, CMIN, 0);
        send(ACT_STEP, 0, 0, 0, 0, 0);
        send(ACT_LOAD_ALL, 0, 64'sd5 <<< FB, -64'sd7 <<< FB, 1, 0);
        send(ACT_STEP, 0, 0, 0, 0, 0);
        send(ACT_LOAD_EIR, -1, CMIN, CMAX, -1, 0);
        send(ACT_LOAD_IR, 0, 0, CMIN, CMAX, 0);
        send(ACT_LOAD_I, 0, 0, -1, 0, 0);
        send(3'd5, CMAX, 1, 1, 1, 0);
        send(3'd7, 0, 0, 0, 0, 0);
        drain();
        write_cfg(REG_POP, 32'd0);
        send(ACT_LOAD_EIR, 0, 64'sd10 <<< FB, 64'sd20 <<< FB, 0, 0);
        send(ACT_LOAD_ALL, 64'sd900 <<< FB, 64'sd10 <<< FB, 64'sd20 <<< FB, 0, 0);
        send(ACT_STEP, 0, 0, 0, 0, 0);
        drain();
        write_cfg(REG_ALPHA, 0);
        write_cfg(REG_BETA1, 0);
        write_cfg(REG_GAMMA, 0);
        write_cfg(REG_BETA2, 0);
        write_cfg(REG_R1, 0);
        write_cfg(REG_R2, 0);
        write_cfg(REG_POP, 32'd1);
        send(ACT_STEP, 0, 0, 0, 0, 0);
        drain();

        // random phases: a load then a run of days
        for (k = 0; k < 8; k++)
        begin
            set_rates(k == 3);
            out_gaps = (k % 4) != 1;
            for (n = 0; n < 250; n++)
            begin
                sel = $urandom_range(0, 99);
                if (n % 40 == 0 || sel < 8)
                    send(ACT_LOAD_ALL, rnd_count(sel % 3), rnd_count(sel % 2),
                         rnd_count(0), rnd_count(1), k % 4 != 2);
                else if (sel < 12)
                    send(ACT_LOAD_EIR, rnd_count(1), rnd_count(0), rnd_count(0),
                         rnd_count(sel % 3), k % 4 != 2);
                else if (sel < 15)
                    send(ACT_LOAD_IR, rnd_count(1), rnd_count(1), rnd_count(0),
                         rnd_count(0), k % 4 != 2);
                else if (sel < 18)
                    send(ACT_LOAD_I, rnd_count(1), rnd_count(1), rnd_count(sel % 3),
                         rnd_count(1), k % 4 != 2);
                else if (sel < 20)
                    send(3'($urandom_range(5, 7)), rnd_count(1), 0, 0, 0, 1);
                else
                    send(ACT_STEP, rnd_count(1), rnd_count(1), rnd_count(1),
                         rnd_count(1), k % 4 != 2);
                // hold off until every result is back
                if (n == 125) while (sb.pending.size() != 0) @(posedge clk);
            end
            drain();
        end

        drain();
        if (sb.errors == 0)
            $display("seir_epidemic_step_top regression: pass");
        else
            $display("seir_epidemic_step_top regression: fail");
        $finish;
    end
endmodule

>>> files.f
rtl/seir_pkg.sv
rtl/seir_epidemic_step_top.sv
bench/tb_top.sv
